// ===== rtl/core/stable_priority_queue_defines.svh =====
// Assertion macros used by the queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic        func;
      logic [3:0]  prio;
      logic [15:0] arrive_time;
      logic [15:0] serve_time;
      logic [15:0] serve_start;
      logic [7:0]  vent_id;
      logic        gender;
      logic [2:0]  age_group;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        empty_res;
      logic        full_res;
      logic [3:0]  out_prio;
      logic [15:0] out_arrive;
      logic [15:0] out_serve;
      logic [15:0] out_start;
      logic [7:0]  out_vent;
      logic        out_gender;
      logic [2:0]  out_age;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0]  prio;
      logic [15:0] arrive;
      logic [15:0] serve;
      logic [15:0] start;
      logic [7:0]  vent;
      logic        gender;
      logic [2:0]  age;
   } record_type;

   // Broadcast to every cell in the chain
   typedef struct packed {
      logic       enq;
      logic       deq;
      record_type new_rec;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/stable_priority_queue.sv =====
// Stable priority queue of patient records, sorted as they are stored.
// Input channel req_: one word per operation, func selects enqueue or
// dequeue. Result channel rsp_: exactly one word per request, in order.
// A chain of QUEUE_DEPTH cells holds the records, head in cell 0; on an
// enqueue every cell compares its priority with the new one and either
// keeps, takes the new record or takes its left neighbour's; on a dequeue
// every cell takes its right neighbour's. Records of equal priority leave
// in arrival order.
// The result is registered and valid in the cycle after acceptance.
// The queue takes one request per cycle while req_stall is low.
// An enqueue into a full queue is dropped with status full; a dequeue on an
// empty queue returns status empty and zero record fields.
// Reset empties the queue at once; no clearing pass is needed.
// While rsp_stall holds a waiting result, req_stall is raised and the
// result word holds until taken; a taken result frees the slot that cycle.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_word_type    rsp_word_ff;
   rsp_word_type    rsp_word_in;

   logic            accept;
   logic            is_full;
   logic            is_empty;
   cell_ctrl_type   ctrl;

   record_type      rec_w  [QUEUE_DEPTH];
   logic            past_w [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CntW'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      ctrl.enq             = accept && (req_word.func == FUNC_ENQ) && !is_full;
      ctrl.deq             = accept && (req_word.func == FUNC_DEQ) && !is_empty;
      ctrl.new_rec.prio    = req_word.prio;
      ctrl.new_rec.arrive  = req_word.arrive_time;
      ctrl.new_rec.serve   = req_word.serve_time;
      ctrl.new_rec.start   = req_word.serve_start;
      ctrl.new_rec.vent    = req_word.vent_id;
      ctrl.new_rec.gender  = req_word.gender;
      ctrl.new_rec.age     = req_word.age_group;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic       left_past;
      record_type left_rec;
      record_type right_rec;

      if (i == 0) begin : g_head
         assign left_past = 1'b1;
         assign left_rec  = ctrl.new_rec;
      end else begin : g_body
         assign left_past = past_w[i-1];
         assign left_rec  = rec_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_rec = rec_w[i];
      end else begin : g_inner
         assign right_rec = rec_w[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (count_ff > CntW'(i)),
         .left_past (left_past),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .past      (past_w[i]),
         .rec       (rec_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CntW'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in           = '0;
         rsp_word_in.empty_res = (count_in == '0);
         rsp_word_in.full_res  = (count_in == CntW'(QUEUE_DEPTH));
         unique case (req_word.func)
            FUNC_ENQ: begin
               rsp_word_in.status = is_full ? ST_FULL : ST_OK;
            end
            FUNC_DEQ: begin
               if (is_empty) begin
                  rsp_word_in.status = ST_EMPTY;
               end else begin
                  rsp_word_in.status     = ST_OK;
                  rsp_word_in.out_prio   = rec_w[0].prio;
                  rsp_word_in.out_arrive = rec_w[0].arrive;
                  rsp_word_in.out_serve  = rec_w[0].serve;
                  rsp_word_in.out_start  = rec_w[0].start;
                  rsp_word_in.out_vent   = rec_w[0].vent;
                  rsp_word_in.out_gender = rec_w[0].gender;
                  rsp_word_in.out_age    = rec_w[0].age;
               end
            end
            default: begin
               rsp_word_in.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QUEUE_DEPTH), "fill count beyond depth")
   `SPQ_ASSERT_NEXT(a_enq_grows, clock, reset, ctrl.enq, count_ff == $past(count_ff) + CntW'(1), "enqueue did not grow the queue")
   `SPQ_ASSERT_NEXT(a_deq_shrinks, clock, reset, ctrl.deq, count_ff == $past(count_ff) - CntW'(1), "dequeue did not shrink the queue")
   `SPQ_ASSERT_SAME(a_full_flag, clock, reset, rsp_valid_ff && (rsp_word_ff.status == ST_FULL), rsp_word_ff.full_res && is_full, "dropped enqueue without full queue")
   `SPQ_ASSERT_SAME(a_empty_flag, clock, reset, rsp_valid_ff && (rsp_word_ff.status == ST_EMPTY), rsp_word_ff.empty_res && (rsp_word_ff.out_prio == '0), "empty dequeue with data")

endmodule

// ===== rtl/core/spq_cell.sv =====
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_past,
   input  spq_pkg::record_type    left_rec,
   input  spq_pkg::record_type    right_rec,
   output logic                   past,
   output spq_pkg::record_type    rec
);
   import spq_pkg::*;

   record_type rec_ff;
   record_type rec_in;

   // New record travels past this cell if it holds equal or higher priority
   assign past = occupied && (rec_ff.prio >= ctrl.new_rec.prio);
   assign rec  = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      priority if (ctrl.enq) begin
         if (!past) begin
            rec_in = left_past ? ctrl.new_rec : left_rec;
         end
      end else if (ctrl.deq) begin
         rec_in = right_rec;
      end else begin
         // hold when the chain is idle
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int DEPTH          = QUEUE_DEPTH_DEF;
   localparam int RANDOM_WORDS   = 1100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 4;

   // Sorted store of patient records plus the results it should produce.
   class triage_board;
      record_type   held[$];
      rsp_word_type outcomes[$];
      int           mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending_count();
         return outcomes.size();
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         record_type   rec;
         int           pos;
         r = '0;
         r.status = ST_OK;
         if (w.func == FUNC_ENQ) begin
            if (held.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               rec.prio   = w.prio;
               rec.arrive = w.arrive_time;
               rec.serve  = w.serve_time;
               rec.start  = w.serve_start;
               rec.vent   = w.vent_id;
               rec.gender = w.gender;
               rec.age    = w.age_group;
               // go behind every record of equal or higher priority
               pos = 0;
               while (pos < held.size() && held[pos].prio >= w.prio) pos++;
               held.insert(pos, rec);
            end
         end else begin
            if (held.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               rec          = held.pop_front();
               r.out_prio   = rec.prio;
               r.out_arrive = rec.arrive;
               r.out_serve  = rec.serve;
               r.out_start  = rec.start;
               r.out_vent   = rec.vent;
               r.out_gender = rec.gender;
               r.out_age    = rec.age;
            end
         end
         r.empty_res = (held.size() == 0);
         r.full_res  = (held.size() >= DEPTH);
         outcomes.push_back(r);
      endfunction

      function void compare_field(string name, longint exp, longint got, time stamp);
         if (exp != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, name, exp, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_word_type got, time stamp);
         rsp_word_type exp;
         if (outcomes.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0h", stamp, got);
            mismatches++;
            return;
         end
         exp = outcomes.pop_front();
         compare_field("status",     exp.status,     got.status,     stamp);
         compare_field("empty_res",  exp.empty_res,  got.empty_res,  stamp);
         compare_field("full_res",   exp.full_res,   got.full_res,   stamp);
         compare_field("out_prio",   exp.out_prio,   got.out_prio,   stamp);
         compare_field("out_arrive", exp.out_arrive, got.out_arrive, stamp);
         compare_field("out_serve",  exp.out_serve,  got.out_serve,  stamp);
         compare_field("out_start",  exp.out_start,  got.out_start,  stamp);
         compare_field("out_vent",   exp.out_vent,   got.out_vent,   stamp);
         compare_field("out_gender", exp.out_gender, got.out_gender, stamp);
         compare_field("out_age",    exp.out_age,    got.out_age,    stamp);
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   triage_board board;
   int          idle_pct    = 18;
   int          quiet_cycles = 0;

   stable_priority_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_word_type rand_word(logic func, logic [3:0] prio);
      req_word_type w;
      w.func        = func;
      w.prio        = prio;
      w.arrive_time = 16'($urandom);
      w.serve_time  = 16'($urandom);
      w.serve_start = 16'($urandom);
      w.vent_id     = 8'($urandom);
      w.gender      = 1'($urandom);
      w.age_group   = 3'($urandom);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      board.note_request(w);
   endtask

   // Receiver: take result words and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_word, $time);
      rsp_stall <= (idle_pct > 0) && ($urandom_range(0, 99) < idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_word_type w;
      logic [3:0]   tie_prios[14];
      int           sent;
      int           burst;
      int           enq_pct;
      int           prio_lo;
      int           prio_hi;
      int           k;
      board = new();
      tie_prios = '{4'd7, 4'd7, 4'd15, 4'd0, 4'd7, 4'd3, 4'd15,
                    4'd3, 4'd7, 4'd0, 4'd12, 4'd12, 4'd1, 4'd7};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // dequeue from an empty queue
      send_word(rand_word(FUNC_DEQ, 4'($urandom)));
      // lowest priority with an all-zero payload, highest with all ones
      w = '0;
      w.func = FUNC_ENQ;
      send_word(w);
      w = '1;
      w.func = FUNC_ENQ;
      send_word(w);
      // fill up with repeated priorities so ties must keep arrival order
      foreach (tie_prios[i]) send_word(rand_word(FUNC_ENQ, tie_prios[i]));
      // enqueue into a full queue is dropped
      send_word(rand_word(FUNC_ENQ, 4'd15));
      repeat (6) send_word(rand_word(FUNC_DEQ, 4'($urandom)));

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_pct = 25;
            1: enq_pct = 50;
            default: enq_pct = 80;
         endcase
         // narrow priority bands give plenty of ties
         if ($urandom_range(0, 1)) begin
            prio_lo = $urandom_range(0, 13);
            prio_hi = prio_lo + 2;
         end else begin
            prio_lo = 0;
            prio_hi = 15;
         end
         for (k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            if (sent == RANDOM_WORDS / 2) begin
               // hold off until every result word has come back
               req_valid <= 1'b0;
               do @(posedge clock); while (board.pending_count() != 0);
            end
            idle_pct = (sent >= 600 && sent < 800) ? 0 : 18;
            if ($urandom_range(0, 99) < enq_pct)
               w = rand_word(FUNC_ENQ, 4'($urandom_range(prio_lo, prio_hi)));
            else
               w = rand_word(FUNC_DEQ, 4'($urandom));
            send_word(w);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (board.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
